@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jmrd_pkg.sv @@
// ---------------------------------------------------------------------------
// jmrd_pkg
// Widths, register map, reset values and direction codes of the ramp drive.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jmrd_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int DZ_W      = 11;
    localparam int DUTY_W    = 12;
    localparam int STEP_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int RUN_W     = DUTY_W + FRAC_BITS + 2;
    localparam int DIFF_W    = RUN_W + 1;
    localparam int PROD_W    = SAMPLE_W + DUTY_W;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_REST_LEVEL = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_LIMIT = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_STEP   = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_REST_LEVEL = SAMPLE_W'(2047);
    localparam logic [DZ_W-1:0]     RST_DEADBAND   = DZ_W'(100);
    localparam logic [DUTY_W-1:0]   RST_DUTY_LIMIT = DUTY_W'(840);
    localparam logic [STEP_W-1:0]   RST_MAX_STEP   = STEP_W'(538);

    // +1.0 and -1.0 in running-duty fixed point
    localparam logic signed [RUN_W-1:0] RUN_ONE  = RUN_W'(1 << FRAC_BITS);
    localparam logic signed [RUN_W-1:0] RUN_MONE = RUN_W'(-(1 << FRAC_BITS));

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

endpackage

@@ rtl/jmrd_mul.sv @@
// ---------------------------------------------------------------------------
// jmrd_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jmrd_mul
    import jmrd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] mcand,
    input  logic [DUTY_W-1:0]   mplier,
    output logic                done,
    output logic [PROD_W-1:0]   product
);

    localparam int CNT_W = $clog2(DUTY_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SAMPLE_W-1:0] mcand_reg;
    logic [SAMPLE_W-1:0] hi_reg;
    logic [DUTY_W-1:0]   lo_reg;
    logic [SAMPLE_W:0]   sum_next;

    // add partial product on LSB, then shift the pair right
    assign sum_next = lo_reg[0] ? ({1'b0, hi_reg} + {1'b0, mcand_reg}) : {1'b0, hi_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DUTY_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end else if (busy_reg) begin
            hi_reg <= sum_next[SAMPLE_W:1];
            lo_reg <= {sum_next[0], lo_reg[DUTY_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

@@ rtl/jmrd_div.sv @@
// ---------------------------------------------------------------------------
// jmrd_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jmrd_div
    import jmrd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [SAMPLE_W-1:0] divisor,
    output logic                done,
    output logic [PROD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SAMPLE_W-1:0] den_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [PROD_W-1:0]   num_reg;     // dividend in, quotient out
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   diff;
    logic                fits;
    logic [SAMPLE_W-1:0] rem_next;

    assign trial    = {rem_reg, num_reg[PROD_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = (trial >= {1'b0, den_reg});
    assign rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= divisor;
            rem_reg <= '0;
            num_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[PROD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

@@ rtl/joystick_motor_ramp_drive.sv @@
// ---------------------------------------------------------------------------
// joystick_motor_ramp_drive
// Joystick sample to bridge drive: dead zone, scaled duty, slew-limited ramp.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Handshake               Payload
//  s_       in   s_valid / s_ready       s_sample
//  m_       out  m_valid / m_ready       m_req_duty, m_drive_direction,
//                                        m_compare_value, m_drive_a, m_drive_b
//  APB      in   psel / penable / pready paddr, pwrite, pwdata, prdata
//
//  A sample outside the dead zone passes from accept through the map state, the
//  serial multiplier, the serial divider (one quotient bit a cycle), the ramp
//  states RAMP and STEP and the result state. Inside the dead zone or with
//  centre not above it the multiply/divide is skipped.
//  One beat in flight; s_ready returns the cycle after the result is loaded,
//  and a new beat is taken while the last result waits on m_.
//  Synchronous active-low reset restores register defaults and zero duty.
//  A stalled m_ port holds the block in its result state until the slot frees.
//
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_motor_ramp_drive
    import jmrd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [DUTY_W-1:0]   m_req_duty,
    output logic [1:0]          m_drive_direction,
    output logic [DUTY_W-1:0]   m_compare_value,
    output logic                m_drive_a,
    output logic                m_drive_b,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // one-hot sequencer
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MAP    = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_RAMP   = 7'b0010000,
        ST_STEP   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [SAMPLE_W-1:0]  rest_level_reg;
    logic [DZ_W-1:0]      deadband_reg;
    logic [DUTY_W-1:0]    duty_limit_reg;
    logic [STEP_W-1:0]    max_step_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_level_reg <= RST_REST_LEVEL;
            deadband_reg   <= RST_DEADBAND;
            duty_limit_reg <= RST_DUTY_LIMIT;
            max_step_reg   <= RST_MAX_STEP;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_REST_LEVEL: rest_level_reg <= pwdata[SAMPLE_W-1:0];
                REG_DEADBAND:   deadband_reg   <= pwdata[DZ_W-1:0];
                REG_DUTY_LIMIT: duty_limit_reg <= pwdata[DUTY_W-1:0];
                REG_MAX_STEP:   max_step_reg   <= pwdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_REST_LEVEL: prdata = DATA_W'(rest_level_reg);
            REG_DEADBAND:   prdata = DATA_W'(deadband_reg);
            REG_DUTY_LIMIT: prdata = DATA_W'(duty_limit_reg);
            REG_MAX_STEP:   prdata = DATA_W'(max_step_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    logic s_fire;
    logic m_valid_reg;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ---------------------------------------------------------------------
    // Map stage: offset from centre, dead-zone test
    // ---------------------------------------------------------------------
    logic [SAMPLE_W-1:0] sample_reg;
    logic                pos;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] dz_ext;
    logic                active;     // outside the dead zone
    logic                scaled;     // centre above dead zone -> divide
    logic [SAMPLE_W-1:0] mag_dz;

    assign pos    = (sample_reg > rest_level_reg);
    assign mag    = pos ? (sample_reg - rest_level_reg) : (rest_level_reg - sample_reg);
    assign dz_ext = SAMPLE_W'(deadband_reg);
    assign active = (mag >= dz_ext);
    assign scaled = (rest_level_reg > dz_ext);
    assign mag_dz = mag - dz_ext;

    // ---------------------------------------------------------------------
    // Serial multiply then divide: (mag - dz) * limit / (centre - dz)
    // ---------------------------------------------------------------------
    logic                mul_start;
    logic                mul_done;
    logic [PROD_W-1:0]   product;
    logic                div_done;
    logic [PROD_W-1:0]   quotient;
    logic [SAMPLE_W-1:0] den_reg;

    assign mul_start = (state_reg == ST_MAP) && active && scaled;

    jmrd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mag_dz),
        .mplier  (duty_limit_reg),
        .done    (mul_done),
        .product (product)
    );

    jmrd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_done),
        .dividend (product),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------------------------------------------------------------
    // Ramp: signed target, slew clamp, stop band
    // ---------------------------------------------------------------------
    logic                     pos_reg;
    logic [DUTY_W-1:0]        tgt_reg;
    logic [DUTY_W-1:0]        tgt_clamped;
    logic signed [DIFF_W-1:0] tgt_ext;
    logic signed [DIFF_W-1:0] tgt_signed;
    logic signed [DIFF_W-1:0] run_ext;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] step_pos;
    logic signed [DIFF_W-1:0] step_neg;
    logic signed [DIFF_W-1:0] delta;
    logic signed [DIFF_W-1:0] run_sum;
    logic signed [RUN_W-1:0]  run_reg;
    logic signed [RUN_W-1:0]  run_neg;
    logic                     go_cw;
    logic                     go_ccw;
    dir_t                     dir_next;
    logic [DUTY_W-1:0]        cmp_next;

    assign tgt_clamped = (quotient > PROD_W'(duty_limit_reg)) ? duty_limit_reg
                                                             : quotient[DUTY_W-1:0];

    assign tgt_ext    = $signed({{(DIFF_W-DUTY_W-FRAC_BITS){1'b0}}, tgt_reg,
                                 {FRAC_BITS{1'b0}}});
    assign tgt_signed = pos_reg ? tgt_ext : -tgt_ext;
    assign run_ext    = $signed({{(DIFF_W-RUN_W){run_reg[RUN_W-1]}}, run_reg});
    assign diff_next  = tgt_signed - run_ext;

    assign step_pos = $signed({{(DIFF_W-STEP_W){1'b0}}, max_step_reg});
    assign step_neg = -step_pos;

    always_comb begin
        if (diff_reg > step_pos) begin
            delta = step_pos;
        end else if (diff_reg < step_neg) begin
            delta = step_neg;
        end else begin
            delta = diff_reg;
        end
    end

    assign run_sum = run_ext + delta;

    // classification of the updated running duty
    assign run_neg = -run_reg;
    assign go_cw   = (run_reg > RUN_ONE);
    assign go_ccw  = (run_reg < RUN_MONE);

    always_comb begin
        if (go_cw) begin
            dir_next = DIR_CW;
            cmp_next = run_reg[FRAC_BITS+DUTY_W-1:FRAC_BITS];
        end else if (go_ccw) begin
            dir_next = DIR_CCW;
            cmp_next = run_neg[FRAC_BITS+DUTY_W-1:FRAC_BITS];
        end else begin
            dir_next = DIR_STOP;
            cmp_next = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_MAP;
            ST_MAP:    state_next = mul_start ? ST_MUL : ST_RAMP;
            ST_MUL:    if (mul_done) state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_RAMP;
            ST_RAMP:   state_next = ST_STEP;
            ST_STEP:   state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_STEP) begin
                run_reg <= run_sum[RUN_W-1:0];
            end
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
                // inside the +/-1.0 band the ramp restarts from zero
                if (!go_cw && !go_ccw) begin
                    run_reg <= '0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    logic [DUTY_W-1:0] m_req_duty_reg;
    logic [1:0]        m_drive_direction_reg;
    logic [DUTY_W-1:0] m_compare_value_reg;
    logic              m_drive_a_reg;
    logic              m_drive_b_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg <= s_sample;
        end
        if (state_reg == ST_MAP) begin
            pos_reg <= pos;
            den_reg <= rest_level_reg - dz_ext;
            tgt_reg <= active ? duty_limit_reg : '0;
        end
        if ((state_reg == ST_DIV) && div_done) begin
            tgt_reg <= tgt_clamped;
        end
        if (state_reg == ST_RAMP) begin
            diff_reg <= diff_next;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_req_duty_reg        <= tgt_reg;
            m_drive_direction_reg <= dir_next;
            m_compare_value_reg   <= cmp_next;
            m_drive_a_reg         <= go_cw;
            m_drive_b_reg         <= go_ccw;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_req_duty        = m_req_duty_reg;
    assign m_drive_direction = m_drive_direction_reg;
    assign m_compare_value   = m_compare_value_reg;
    assign m_drive_a         = m_drive_a_reg;
    assign m_drive_b         = m_drive_b_reg;

endmodule

@@ rtl/jmrd_checker.sv @@
// ---------------------------------------------------------------------------
// jmrd_checker
// Port-level checks of the ramp drive, bound onto the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jmrd_checker
    import jmrd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DUTY_W-1:0] m_req_duty,
    input logic [1:0]        m_drive_direction,
    input logic [DUTY_W-1:0] m_compare_value,
    input logic              m_drive_a,
    input logic              m_drive_b,
    input logic              pready
);

    logic                       stalled;
    logic [2*DUTY_W+3:0]        beat_bits;
    logic                       bridge_ok;
    logic                       stop_ok;

    assign stalled   = m_valid && !m_ready;
    assign beat_bits = {m_req_duty, m_drive_direction, m_compare_value, m_drive_a, m_drive_b};
    assign bridge_ok = (m_drive_a == (m_drive_direction == DIR_CW))
                    && (m_drive_b == (m_drive_direction == DIR_CCW));
    assign stop_ok   = ((m_drive_direction == DIR_STOP) == (m_compare_value == '0));

    // stalled beat holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, stalled, m_valid && $stable(beat_bits), "m_ beat changed")

    // bridge pins follow the direction code
    `ASSERT_IMPLY(a_bridge, aclk, aresetn, m_valid, bridge_ok, "bridge pins disagree with direction")

    // stop exactly when compare value is zero
    `ASSERT_IMPLY(a_stop_cmp, aclk, aresetn, m_valid, stop_ok, "stop and compare value disagree")

    `ASSERT_ALWAYS(a_pready, aclk, aresetn, pready, "pready dropped")

endmodule

bind joystick_motor_ramp_drive jmrd_checker u_jmrd_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_req_duty        (m_req_duty),
    .m_drive_direction (m_drive_direction),
    .m_compare_value   (m_compare_value),
    .m_drive_a         (m_drive_a),
    .m_drive_b         (m_drive_b),
    .pready            (pready)
);

@@ tb/tb_joystick_motor_ramp_drive.sv @@
// ---------------------------------------------------------------------------
// tb_joystick_motor_ramp_drive
// Self-checking bench for the joystick ramp drive. Samples go in on s_ and
// results come out on m_. A cycle-free model of the dead zone, duty mapping
// and slew limiter forecasts every result beat. Registers are set over APB
// only while the block is idle, and each one is read back after it is set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_joystick_motor_ramp_drive;
    import jmrd_pkg::*;

    // Quiet cycles (no beat on either channel, no APB access) before giving up.
    // It sits far above the slowest beat and the random gaps (drawn at up to 53 %).
    localparam int QUIET_LIMIT   = 4000;
    // Settle time after draining
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [DUTY_W-1:0] req_duty;
        dir_t              direction;
        logic [DUTY_W-1:0] compare_value;
        logic              drive_a;
        logic              drive_b;
    } drive_beat_t;

    typedef enum int {
        GAP_NONE,
        GAP_SENDER,
        GAP_RECEIVER,
        GAP_BOTH
    } gap_mode_t;

    // Clock, reset and DUT-facing signals; every input starts at a known value
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic [DUTY_W-1:0]   m_req_duty;
    logic [1:0]          m_drive_direction;
    logic [DUTY_W-1:0]   m_compare_value;
    logic                m_drive_a;
    logic                m_drive_b;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Model copy of the register file and of the running duty (8 fraction bits)
    logic [SAMPLE_W-1:0] cfg_rest_level = RST_REST_LEVEL;
    logic [DZ_W-1:0]     cfg_deadband   = RST_DEADBAND;
    logic [DUTY_W-1:0]   cfg_duty_limit = RST_DUTY_LIMIT;
    logic [STEP_W-1:0]   cfg_max_step   = RST_MAX_STEP;
    longint              model_running_duty = 0;

    logic [SAMPLE_W-1:0] sample_queue[$];          // samples waiting for the driver
    drive_beat_t         pending_drive_results[$]; // forecast beats, oldest first
    drive_beat_t         want;
    gap_mode_t           gap_mode = GAP_NONE;
    int                  mismatch_count = 0;
    int                  quiet_cycles = 0;

    always #5 aclk = ~aclk;

    joystick_motor_ramp_drive dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_req_duty        (m_req_duty),
        .m_drive_direction (m_drive_direction),
        .m_compare_value   (m_compare_value),
        .m_drive_a         (m_drive_a),
        .m_drive_b         (m_drive_b),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // -----------------------------------------------------------------------
    // Model: one sample in, one result beat out. The running duty moves
    // toward the signed request by at most max_step. Inside +/-1.0 it is
    // forced back to zero.
    // -----------------------------------------------------------------------
    function automatic drive_beat_t ramp_drive_predict(input logic [SAMPLE_W-1:0] smp);
        longint      s, ctr, dz, lim, stp, mag, q, tgt, request, delta, one;
        bit          above;
        drive_beat_t r;
        s   = longint'(smp);
        ctr = longint'(cfg_rest_level);
        dz  = longint'(cfg_deadband);
        lim = longint'(cfg_duty_limit);
        stp = longint'(cfg_max_step);
        one = longint'(1) << FRAC_BITS;
        above   = s > ctr;
        mag     = above ? s - ctr : ctr - s;
        tgt     = 0;
        request = 0;
        if (mag >= dz) begin
            if (ctr > dz) begin
                q   = ((mag - dz) * lim) / (ctr - dz);
                tgt = (q > lim) ? lim : q;
            end else begin
                // centre not above the dead zone: full duty, no divide
                tgt = lim;
            end
            request = tgt << FRAC_BITS;
            // at the centre with no dead zone this gives -0, i.e. zero
            if (!above) request = -request;
        end
        delta = request - model_running_duty;
        if (delta > stp) delta = stp;
        else if (delta < -stp) delta = -stp;
        model_running_duty += delta;

        r.req_duty = tgt[DUTY_W-1:0];
        if (model_running_duty > one) begin
            r.direction     = DIR_CW;
            r.compare_value = DUTY_W'(model_running_duty >>> FRAC_BITS);
        end else if (model_running_duty < -one) begin
            r.direction     = DIR_CCW;
            r.compare_value = DUTY_W'((-model_running_duty) >>> FRAC_BITS);
        end else begin
            r.direction        = DIR_STOP;
            r.compare_value    = '0;
            model_running_duty = 0;
        end
        r.drive_a = (r.direction == DIR_CW);
        r.drive_b = (r.direction == DIR_CCW);
        return r;
    endfunction

    function automatic bit sender_gap();
        case (gap_mode)
            GAP_SENDER: return $urandom_range(0, 99) < 53;
            GAP_BOTH:   return $urandom_range(0, 99) < 18;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (gap_mode)
            GAP_RECEIVER: return $urandom_range(0, 99) < 53;
            GAP_BOTH:     return $urandom_range(0, 99) < 18;
            default:      return 1'b0;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Driver: forecast on every accepted beat, then present the next sample
    // only once the slot is free. s_valid gets at most one NBA per edge.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                pending_drive_results.push_back(ramp_drive_predict(s_sample));
            if (!s_valid || s_ready) begin
                if (sample_queue.size() > 0 && !sender_gap()) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: compare each result beat against the oldest forecast, field by
    // field. Backpressure on m_ready is redrawn each cycle.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_drive_results.size() == 0) begin
                    $error("result beat with no sample outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_drive_results.pop_front();
                    if (m_req_duty !== want.req_duty) begin
                        $error("req_duty: expected %0d, actual %0d",
                               want.req_duty, m_req_duty);
                        mismatch_count++;
                    end
                    if (m_drive_direction !== want.direction) begin
                        $error("drive_direction: expected %0d, actual %0d",
                               want.direction, m_drive_direction);
                        mismatch_count++;
                    end
                    if (m_compare_value !== want.compare_value) begin
                        $error("compare_value: expected %0d, actual %0d",
                               want.compare_value, m_compare_value);
                        mismatch_count++;
                    end
                    if (m_drive_a !== want.drive_a) begin
                        $error("drive_a: expected %0d, actual %0d", want.drive_a, m_drive_a);
                        mismatch_count++;
                    end
                    if (m_drive_b !== want.drive_b) begin
                        $error("drive_b: expected %0d, actual %0d", want.drive_b, m_drive_b);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= !receiver_stall();
        end
    end

    // Watchdog: any beat or APB access resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // APB access: setup cycle, then access cycle. The register is written,
    // or prdata is taken, at the edge that closes the access cycle.
    // -----------------------------------------------------------------------
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_REST_LEVEL: cfg_rest_level = value[SAMPLE_W-1:0];
            REG_DEADBAND:   cfg_deadband   = value[DZ_W-1:0];
            REG_DUTY_LIMIT: cfg_duty_limit = value[DUTY_W-1:0];
            REG_MAX_STEP:   cfg_max_step   = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_read_check(input logic [REG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value, input string label);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== value) begin
            $error("%s: expected %0d, actual %0d", label, value, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back_all();
        apb_read_check(REG_REST_LEVEL, DATA_W'(cfg_rest_level), "rest_level");
        apb_read_check(REG_DEADBAND,   DATA_W'(cfg_deadband),   "deadband");
        apb_read_check(REG_DUTY_LIMIT, DATA_W'(cfg_duty_limit), "duty_limit");
        apb_read_check(REG_MAX_STEP,   DATA_W'(cfg_max_step),   "max_step");
    endtask

    // Only called with the block idle (see wait_drained)
    task automatic set_ramp_config(input int ctr, input int dz, input int lim, input int stp);
        apb_write(REG_REST_LEVEL, DATA_W'(ctr));
        apb_write(REG_DEADBAND,   DATA_W'(dz));
        apb_write(REG_DUTY_LIMIT, DATA_W'(lim));
        apb_write(REG_MAX_STEP,   DATA_W'(stp));
        read_back_all();
    endtask

    // Queue changes land on the falling edge, clear of the driver's edge
    task automatic push_sample(input int v);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        sample_queue.push_back(SAMPLE_W'(v));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (sample_queue.size() != 0 || s_valid || pending_drive_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly held deflections so the ramp climbs well past the stop band,
    // with single noise samples, dead-zone boundary hits and full-scale flips.
    task automatic queue_random_samples(input int n);
        int left, kind, held, off, v;
        left = n;
        @(negedge aclk);
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                if ($urandom_range(0, 1)) begin
                    v = int'($urandom_range(0, 4095));
                end else begin
                    off = int'(cfg_deadband) + int'($urandom_range(0, 300));
                    v = $urandom_range(0, 1) ? int'(cfg_rest_level) + off
                                             : int'(cfg_rest_level) - off;
                end
                held = int'($urandom_range(1, 40));
                if (held > left) held = left;
                repeat (held) push_sample(v);
                left -= held;
            end else if (kind <= 7) begin
                push_sample(int'($urandom_range(0, 4095)));
                left--;
            end else if (kind == 8) begin
                off = int'(cfg_deadband) + int'($urandom_range(0, 2)) - 1;
                push_sample($urandom_range(0, 1) ? int'(cfg_rest_level) + off
                                                 : int'(cfg_rest_level) - off);
                left--;
            end else begin
                push_sample($urandom_range(0, 1) ? 4095 : 0);
                left--;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence: reset, directed corners, then random phases across settings
    // and idle modes.
    // -----------------------------------------------------------------------
    initial begin : sequencer
        int ph, ctr, dz, lim, stp;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values must read back as the defaults
        read_back_all();

        // Defaults: full deflection both ways, rest position, dead-zone edges
        @(negedge aclk);
        push_sample(0);
        push_sample(4095);
        push_sample(4095);
        push_sample(2047);
        push_sample(2146);
        push_sample(2147);
        push_sample(1947);
        push_sample(1948);
        push_sample(0);
        push_sample(0);
        wait_drained();

        // exactly at the centre with no dead zone: counterclockwise, zero duty
        set_ramp_config(2000, 0, 840, 538);
        @(negedge aclk);
        push_sample(2000);
        push_sample(4095);
        push_sample(2000);
        wait_drained();

        // centre not above the dead zone: full duty outside the band
        set_ramp_config(50, 100, 4095, 65535);
        @(negedge aclk);
        push_sample(4095);
        push_sample(0);
        push_sample(60);
        wait_drained();

        // mapped duty past the limit gets clamped
        set_ramp_config(1000, 0, 4095, 65535);
        @(negedge aclk);
        push_sample(4095);
        push_sample(0);
        wait_drained();

        // widest dead zone
        set_ramp_config(2047, 2047, 840, 538);
        @(negedge aclk);
        push_sample(0);
        push_sample(4095);
        push_sample(1);
        wait_drained();

        // zero duty limit, then zero step: request stays zero / ramp frozen
        set_ramp_config(2047, 100, 0, 538);
        @(negedge aclk);
        push_sample(4095);
        wait_drained();
        set_ramp_config(2047, 100, 840, 0);
        @(negedge aclk);
        push_sample(4095);
        wait_drained();

        // Random phases: defaults and extremes first, then random settings
        for (ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin ctr = 2047; dz = 100;  lim = 840;  stp = 538;   end
                1: begin ctr = 0;    dz = 0;    lim = 4095; stp = 65535; end
                2: begin ctr = 4095; dz = 2047; lim = 1;    stp = 1;     end
                3: begin ctr = 2047; dz = 0;    lim = 4095; stp = 65535; end
                default: begin
                    ctr = int'($urandom_range(0, 4095));
                    dz  = int'($urandom_range(0, 2047));
                    lim = int'($urandom_range(1, 4095));
                    stp = $urandom_range(0, 1) ? int'($urandom_range(1, 65535))
                                               : int'($urandom_range(1, 2000));
                end
            endcase
            set_ramp_config(ctr, dz, lim, stp);
            @(negedge aclk);
            gap_mode = gap_mode_t'(ph % 4);
            queue_random_samples(155);
            wait_drained();
        end

        if (mismatch_count == 0 && pending_drive_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/jmrd_pkg.sv
rtl/jmrd_mul.sv
rtl/jmrd_div.sv
rtl/joystick_motor_ramp_drive.sv
rtl/jmrd_checker.sv
tb/tb_joystick_motor_ramp_drive.sv
